// ===== design/bbts_pkg.sv =====
// ----------------------------------------------------------------------------
// bbts_pkg
// Shared types and codes of the buzzer beep and tune sequencer.
// ----------------------------------------------------------------------------
package bbts_pkg;

    // item kinds
    localparam logic [2:0] KIND_TICK  = 3'd0;
    localparam logic [2:0] KIND_BEEP  = 3'd1;
    localparam logic [2:0] KIND_LOAD  = 3'd2;
    localparam logic [2:0] KIND_START = 3'd3;
    localparam logic [2:0] KIND_STOP  = 3'd4;

    // configuration register indexes
    localparam logic [1:0] CFG_VOLUME = 2'd0;
    localparam logic [1:0] CFG_BASE   = 2'd1;
    localparam logic [1:0] CFG_RATIO  = 2'd2;

    // note codes
    localparam logic [3:0] NOTE_REST = 4'd0;
    localparam logic [3:0] NOTE_LAST = 4'd12;
    localparam logic [3:0] NOTE_END  = 4'd13;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  beep_count;
        logic [15:0] beep_period_ms;
        logic [3:0]  note;
        logic [3:0]  octave;
        logic        keep_tone;
        logic [7:0]  song_index;
        logic [15:0] note_length_ms;
        logic [15:0] note_break_ms;
    } in_item_t;

    typedef struct packed {
        logic [15:0] reload_period;
        logic [15:0] compare_value;
        logic        beeping;
        logic        song_playing;
    } out_item_t;

    typedef struct packed {
        logic        load_base;
        logic        load_ratio;
        logic [15:0] wdata;
    } tbl_ctl_t;

endpackage

// ===== design/buzzer_beep_and_tune_sequencer.sv =====
// ----------------------------------------------------------------------------
// buzzer_beep_and_tune_sequencer
// Millisecond-tick buzzer sequencer giving PWM reload and compare values.
// ----------------------------------------------------------------------------
// Items enter on the s_ channel (valid/ready) and each one gives exactly one
// result on the m_ channel: reload period, compare value and the beep and
// song status after the item. Tick items come once per millisecond; other
// kinds set the tone or start a beep pattern, load a song slot, start or stop the song.
// Registers are written through cfg_wr_en / cfg_index / cfg_wdata.
// Throughput is one item per cycle while m_ready is high and no table
// rebuild runs. An accepted item is registered in turn through song memory
// read, state update, volume multiply, divide-by-100 multiply and output
// register. The note table is built by a serial divider, 30 steps per
// entry: after reset and after each base period or ratio write, s_ready
// stays low while the 12 entries are rebuilt.
// Reset clears the status and the pipeline; song memory contents are kept
// and slots are only meaningful once loaded.
// When m_ready is low the stages fill up behind the output register and
// s_ready drops, table rebuilds apart, only once every stage holds an item.
// ----------------------------------------------------------------------------
module buzzer_beep_and_tune_sequencer
    import bbts_pkg::*;
#(
    parameter int unsigned SONG_DEPTH = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_item_t    s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output out_item_t   m_data
);

    localparam int unsigned         ADDR_W       = $clog2(SONG_DEPTH);
    localparam logic [ADDR_W-1:0]   POS_LAST     = ADDR_W'(SONG_DEPTH - 1);
    localparam logic [6:0]          VOLUME_RESET = 7'd25;
    localparam logic [6:0]          VOLUME_MAX   = 7'd100;
    localparam logic [23:0]         RECIP_100    = 24'd10737419;

    typedef enum logic [1:0] {CMP_HOLD, CMP_ZERO, CMP_ON} cmp_op_t;

    typedef struct packed {
        cmp_op_t     op;
        logic [15:0] period;
        logic        beeping;
        logic        playing;
    } stage_t;

    // slot of a song index, modulo the depth
    logic [ADDR_W-1:0] slot_of [256];
    for (genvar g = 0; g < 256; g++) begin : g_slot
        assign slot_of[g] = ADDR_W'(g % SONG_DEPTH);
    end

    logic [6:0]        volume_reg;
    logic [7:0]        song_mem [SONG_DEPTH];
    logic [7:0]        rdata_reg;
    logic [ADDR_W-1:0] raddr;

    logic              s1_valid_reg;
    in_item_t          s1_item_reg;
    logic              s2_valid_reg;
    stage_t            s2_reg;
    logic              s3_valid_reg;
    stage_t            s3_reg;
    logic [22:0]       s3_prod_reg;
    logic              s4_valid_reg;
    stage_t            s4_reg;
    logic [15:0]       s4_cmp_reg;
    logic              m_valid_reg;
    out_item_t         m_data_reg;
    logic [15:0]       cmp_hold_reg;
    logic [15:0]       cmp_next;
    logic [46:0]       scaled;

    logic              beep_on_reg, beep_on_next;
    logic [7:0]        beeps_left_reg, beeps_left_next;
    logic [15:0]       beep_len_reg, beep_len_next;
    logic [15:0]       beep_left_reg, beep_left_next;
    logic [15:0]       tone_period_reg, tone_period_next;
    logic              song_active_reg, song_active_next;
    logic [ADDR_W-1:0] pos_reg, pos_next;
    logic [15:0]       note_len_reg, note_len_next;
    logic [15:0]       song_left_reg, song_left_next;
    logic [15:0]       gap_len_reg, gap_len_next;
    logic              in_gap_reg, in_gap_next;
    logic [7:0]        cur_entry_reg, cur_entry_next;

    logic              rdy_out, rdy4, rdy3, rdy2, rdy1;
    logic              fire1, s_accept;
    logic              tbl_busy;
    tbl_ctl_t          tbl_ctl;
    logic [3:0]        look_note, look_octave;
    logic [15:0]       look_period;
    stage_t            s1_out;
    logic [ADDR_W-1:0] pos_fwd;
    logic [ADDR_W-1:0] pos_fwd_inc;

    // stage handshake
    assign rdy_out  = !m_valid_reg || m_ready;
    assign rdy4     = !s4_valid_reg || rdy_out;
    assign rdy3     = !s3_valid_reg || rdy4;
    assign rdy2     = !s2_valid_reg || rdy3;
    assign rdy1     = !s1_valid_reg || rdy2;
    assign fire1    = s1_valid_reg && rdy2;
    assign s_ready  = rdy1 && !tbl_busy;
    assign s_accept = s_valid && s_ready;

    // configuration
    assign tbl_ctl.load_base  = cfg_wr_en && (cfg_index == CFG_BASE);
    assign tbl_ctl.load_ratio = cfg_wr_en && (cfg_index == CFG_RATIO);
    assign tbl_ctl.wdata      = cfg_wdata;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            volume_reg <= VOLUME_RESET;
        end else if (cfg_wr_en && cfg_index == CFG_VOLUME) begin
            volume_reg <= (cfg_wdata[6:0] > VOLUME_MAX) ? VOLUME_MAX : cfg_wdata[6:0];
        end
    end

    bbts_note_table u_note_table (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctl         (tbl_ctl),
        .busy        (tbl_busy),
        .look_note   (look_note),
        .look_octave (look_octave),
        .look_period (look_period)
    );

    // song memory: read the entry after the forwarded position, or slot 0 on start
    assign pos_fwd     = fire1 ? pos_next : pos_reg;
    assign pos_fwd_inc = (pos_fwd == POS_LAST) ? '0 : pos_fwd + 1'b1;
    assign raddr       = (s_data.kind == KIND_START) ? '0 : pos_fwd_inc;

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            if (s_data.kind == KIND_LOAD) begin
                song_mem[slot_of[s_data.song_index]] <= {s_data.octave, s_data.note};
            end
            rdata_reg <= song_mem[raddr];
        end
    end

    // state update stage
    always_comb begin
        logic advance;
        logic [15:0] beep_dec;
        logic [ADDR_W-1:0] pos_inc;

        advance          = 1'b0;
        beep_dec         = beep_left_reg - 16'd1;
        pos_inc          = (pos_reg == POS_LAST) ? '0 : pos_reg + 1'b1;
        beep_on_next     = beep_on_reg;
        beeps_left_next  = beeps_left_reg;
        beep_len_next    = beep_len_reg;
        beep_left_next   = beep_left_reg;
        tone_period_next = tone_period_reg;
        song_active_next = song_active_reg;
        pos_next         = pos_reg;
        note_len_next    = note_len_reg;
        song_left_next   = song_left_reg;
        gap_len_next     = gap_len_reg;
        in_gap_next      = in_gap_reg;
        cur_entry_next   = cur_entry_reg;
        s1_out.op        = CMP_HOLD;

        if (s1_item_reg.kind == KIND_BEEP) begin
            look_note   = s1_item_reg.note;
            look_octave = s1_item_reg.octave;
        end else begin
            look_note   = rdata_reg[3:0];
            look_octave = rdata_reg[7:4];
        end

        case (s1_item_reg.kind)
            KIND_TICK: begin
                if (beep_on_reg || beeps_left_reg != '0) begin
                    if (beep_dec == '0) begin
                        beep_on_next   = !beep_on_reg;
                        beep_left_next = beep_len_reg;
                        if (!beep_on_reg) begin
                            s1_out.op = CMP_ON;
                        end else begin
                            s1_out.op       = CMP_ZERO;
                            beeps_left_next = beeps_left_reg - 8'd1;
                        end
                    end else begin
                        beep_left_next = beep_dec;
                    end
                end else if (song_active_reg) begin
                    if (cur_entry_reg[3:0] == NOTE_END) begin
                        song_active_next = 1'b0;
                        s1_out.op        = CMP_ZERO;
                    end else if (song_left_reg != '0) begin
                        song_left_next = song_left_reg - 16'd1;
                    end else begin
                        song_left_next = note_len_reg;
                        advance        = 1'b1;
                        if (gap_len_reg != '0) begin
                            in_gap_next = !in_gap_reg;
                            if (!in_gap_reg) begin
                                song_left_next = gap_len_reg;
                                s1_out.op      = CMP_ZERO;
                                advance        = 1'b0;
                            end
                        end
                        if (advance) begin
                            pos_next         = pos_inc;
                            cur_entry_next   = rdata_reg;
                            tone_period_next = look_period;
                            s1_out.op        = CMP_ON;
                        end
                    end
                end
            end
            KIND_BEEP: begin
                if (!s1_item_reg.keep_tone) begin
                    tone_period_next = look_period;
                    if (look_period == '0) begin
                        s1_out.op = CMP_ZERO;
                    end
                end
                if (s1_item_reg.beep_count != '0 && s1_item_reg.beep_period_ms != '0) begin
                    beeps_left_next  = s1_item_reg.beep_count;
                    beep_len_next    = s1_item_reg.beep_period_ms;
                    beep_left_next   = s1_item_reg.beep_period_ms;
                    beep_on_next     = 1'b1;
                    song_active_next = 1'b0;
                    s1_out.op        = CMP_ON;
                end
            end
            KIND_LOAD: begin
                // keep the cached current entry in step with the memory
                if (slot_of[s1_item_reg.song_index] == pos_reg) begin
                    cur_entry_next = {s1_item_reg.octave, s1_item_reg.note};
                end
            end
            KIND_START: begin
                beep_on_next     = 1'b0;
                beeps_left_next  = '0;
                song_active_next = 1'b1;
                pos_next         = '0;
                note_len_next    = s1_item_reg.note_length_ms;
                song_left_next   = s1_item_reg.note_length_ms;
                gap_len_next     = s1_item_reg.note_break_ms;
                in_gap_next      = 1'b0;
                cur_entry_next   = rdata_reg;
                tone_period_next = look_period;
                s1_out.op        = CMP_ON;
            end
            KIND_STOP: begin
                song_active_next = 1'b0;
            end
            default: begin
            end
        endcase

        s1_out.period  = tone_period_next;
        s1_out.beeping = beep_on_next || (beeps_left_next != '0);
        s1_out.playing = song_active_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            beep_on_reg     <= 1'b0;
            beeps_left_reg  <= '0;
            beep_len_reg    <= '0;
            beep_left_reg   <= '0;
            tone_period_reg <= 16'd1;
            song_active_reg <= 1'b0;
            pos_reg         <= '0;
            note_len_reg    <= '0;
            song_left_reg   <= '0;
            gap_len_reg     <= '0;
            in_gap_reg      <= 1'b0;
            cur_entry_reg   <= '0;
        end else if (fire1) begin
            beep_on_reg     <= beep_on_next;
            beeps_left_reg  <= beeps_left_next;
            beep_len_reg    <= beep_len_next;
            beep_left_reg   <= beep_left_next;
            tone_period_reg <= tone_period_next;
            song_active_reg <= song_active_next;
            pos_reg         <= pos_next;
            note_len_reg    <= note_len_next;
            song_left_reg   <= song_left_next;
            gap_len_reg     <= gap_len_next;
            in_gap_reg      <= in_gap_next;
            cur_entry_reg   <= cur_entry_next;
        end
    end

    // compare value: period * volume, then divide by 100 through a reciprocal
    assign scaled = {24'd0, s3_prod_reg} * {23'd0, RECIP_100};

    always_comb begin
        if (s4_reg.op == CMP_ON) begin
            cmp_next = s4_cmp_reg;
        end else if (s4_reg.op == CMP_ZERO) begin
            cmp_next = '0;
        end else begin
            cmp_next = cmp_hold_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            cmp_hold_reg <= '0;
        end else begin
            if (rdy1) begin
                s1_valid_reg <= s_accept;
            end
            if (rdy2) begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (rdy3) begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (rdy4) begin
                s4_valid_reg <= s3_valid_reg;
            end
            if (rdy_out) begin
                m_valid_reg <= s4_valid_reg;
            end
            if (rdy_out && s4_valid_reg) begin
                cmp_hold_reg <= cmp_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_item_reg <= s_data;
        end
        if (rdy2) begin
            s2_reg <= s1_out;
        end
        if (rdy3) begin
            s3_reg      <= s2_reg;
            s3_prod_reg <= {7'd0, s2_reg.period} * {16'd0, volume_reg};
        end
        if (rdy4) begin
            s4_reg     <= s3_reg;
            s4_cmp_reg <= scaled[45:30];
        end
        if (rdy_out && s4_valid_reg) begin
            m_data_reg.reload_period <= s4_reg.period;
            m_data_reg.compare_value <= cmp_next;
            m_data_reg.beeping       <= s4_reg.beeping;
            m_data_reg.song_playing  <= s4_reg.playing;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== design/bbts_note_table.sv =====
// ----------------------------------------------------------------------------
// bbts_note_table
// Semitone period table, rebuilt by a serial divider after reset and after
// a write of the base period or the semitone ratio.
// ----------------------------------------------------------------------------
module bbts_note_table
    import bbts_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  tbl_ctl_t    ctl,
    output logic        busy,
    input  logic [3:0]  look_note,
    input  logic [3:0]  look_octave,
    output logic [15:0] look_period
);

    localparam logic [15:0] BASE_RESET  = 16'd61162;
    localparam logic [14:0] RATIO_RESET = 15'd10595;
    localparam logic [13:0] RATIO_SCALE = 14'd10000;
    localparam int unsigned QUO_W       = 30;
    localparam logic [4:0]  LAST_STEP   = 5'(QUO_W - 1);

    typedef enum logic [1:0] {TB_IDLE, TB_LOAD, TB_MUL, TB_DIV} tb_state_t;

    tb_state_t        state_reg;
    logic [15:0]      base_reg;
    logic [14:0]      ratio_reg;
    logic [15:0]      tbl_reg [12];
    logic [15:0]      prev_reg;
    logic [3:0]       note_idx_reg;
    logic [4:0]       step_reg;
    logic [14:0]      rem_reg;
    logic [QUO_W-1:0] quo_reg;

    logic [15:0]      rem_shift;
    logic             rem_ge;
    logic [14:0]      rem_next;
    logic [QUO_W-1:0] quo_next;
    logic [15:0]      entry_sat;
    logic [3:0]       wr_slot;

    // one restoring division step per cycle
    always_comb begin
        rem_shift = {rem_reg, quo_reg[QUO_W-1]};
        rem_ge    = rem_shift >= {1'b0, ratio_reg};
        rem_next  = rem_ge ? 15'(rem_shift - {1'b0, ratio_reg}) : rem_shift[14:0];
        quo_next  = {quo_reg[QUO_W-2:0], rem_ge};
        entry_sat = (|quo_next[QUO_W-1:16]) ? 16'hFFFF : quo_next[15:0];
        wr_slot   = note_idx_reg - 4'd1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= TB_LOAD;
            base_reg  <= BASE_RESET;
            ratio_reg <= RATIO_RESET;
        end else begin
            if (ctl.load_base) begin
                base_reg <= ctl.wdata;
            end
            if (ctl.load_ratio) begin
                ratio_reg <= ctl.wdata[14:0];
            end
            if (ctl.load_base || ctl.load_ratio) begin
                state_reg <= TB_LOAD;
            end else begin
                case (state_reg)
                    TB_LOAD: begin
                        tbl_reg[0]   <= base_reg;
                        prev_reg     <= base_reg;
                        note_idx_reg <= 4'd2;
                        state_reg    <= TB_MUL;
                    end
                    TB_MUL: begin
                        if (ratio_reg == '0) begin
                            tbl_reg[wr_slot] <= 16'hFFFF;
                            prev_reg         <= 16'hFFFF;
                            note_idx_reg     <= note_idx_reg + 4'd1;
                            if (note_idx_reg == NOTE_LAST) begin
                                state_reg <= TB_IDLE;
                            end
                        end else begin
                            quo_reg   <= {14'd0, prev_reg} * {16'd0, RATIO_SCALE};
                            rem_reg   <= '0;
                            step_reg  <= '0;
                            state_reg <= TB_DIV;
                        end
                    end
                    TB_DIV: begin
                        rem_reg  <= rem_next;
                        quo_reg  <= quo_next;
                        step_reg <= step_reg + 5'd1;
                        if (step_reg == LAST_STEP) begin
                            tbl_reg[wr_slot] <= entry_sat;
                            prev_reg         <= entry_sat;
                            note_idx_reg     <= note_idx_reg + 4'd1;
                            state_reg        <= (note_idx_reg == NOTE_LAST) ? TB_IDLE : TB_MUL;
                        end
                    end
                    default: begin
                        state_reg <= TB_IDLE;
                    end
                endcase
            end
        end
    end

    assign busy = (state_reg != TB_IDLE);

    always_comb begin
        if (look_note == NOTE_REST || look_note > NOTE_LAST) begin
            look_period = '0;
        end else begin
            look_period = tbl_reg[look_note - 4'd1] >> look_octave;
        end
    end

endmodule

// ===== design/bbts_checker.sv =====
// ----------------------------------------------------------------------------
// bbts_checker
// Port-level checks of the buzzer sequencer, bound to the top level.
// ----------------------------------------------------------------------------
module bbts_checker
    import bbts_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        cfg_wr_en,
    input logic [1:0]  cfg_index,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input out_item_t   m_data
);

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // beep pattern and song never run together
    a_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_data.beeping && m_data.song_playing))
        else $error("beep and song both active");

    // a silent period always comes with compare off
    a_silent_off: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.reload_period == 16'd0 |-> m_data.compare_value == 16'd0)
        else $error("compare set with silent period");

    // table rebuild blocks input
    a_rebuild: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_wr_en && (cfg_index == CFG_BASE || cfg_index == CFG_RATIO) |=> !s_ready)
        else $error("input taken during table rebuild");

endmodule

bind buzzer_beep_and_tune_sequencer bbts_checker u_bbts_checker (.*);
